// File: rtl/dvap_pkg.sv
package dvap_pkg;

  localparam int ADDR_BITS_DEFAULT = 32;
  localparam int DELTA_BITS = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int COUNT_BITS = 3;
  localparam int GROUP_BITS = 7;

  localparam logic [7:0] MORE_FLAG = 8'h80;
  localparam logic [GROUP_BITS-1:0] GROUP_MASK = 7'h7F;

  localparam logic [DELTA_BITS-1:0] NEED5_MASK = 32'hF000_0000;
  localparam logic [DELTA_BITS-1:0] NEED4_MASK = 32'hFFE0_0000;
  localparam logic [DELTA_BITS-1:0] NEED3_MASK = 32'hFFFF_C000;
  localparam logic [DELTA_BITS-1:0] NEED2_MASK = 32'hFFFF_FF80;

  typedef struct packed {
    logic [31:0] address;
    logic        start_table;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } out_item_t;

  // One queued delta and the number of code bytes it needs (1 to 5).
  typedef struct packed {
    logic [DELTA_BITS-1:0] delta;
    logic [COUNT_BITS-1:0] nbytes;
  } job_t;

  function automatic logic [COUNT_BITS-1:0] byte_count(input logic [DELTA_BITS-1:0] d);
    logic [COUNT_BITS-1:0] n;
    if ((d & NEED5_MASK) != '0) begin
      n = 3'd5;
    end else if ((d & NEED4_MASK) != '0) begin
      n = 3'd4;
    end else if ((d & NEED3_MASK) != '0) begin
      n = 3'd3;
    end else if ((d & NEED2_MASK) != '0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  // Group k of the delta, counted from the least significant end.
  function automatic logic [GROUP_BITS-1:0] group_of(input logic [DELTA_BITS-1:0] d,
                                                     input logic [COUNT_BITS-1:0] k);
    logic [GROUP_BITS-1:0] g;
    case (k)
      3'd0:    g = d[6:0];
      3'd1:    g = d[13:7];
      3'd2:    g = d[20:14];
      3'd3:    g = d[27:21];
      default: g = {3'b000, d[31:28]};
    endcase
    return g & GROUP_MASK;
  endfunction

endpackage

// File: rtl/dvap_front.sv
module dvap_front #(
  parameter int ADDR_BITS = dvap_pkg::ADDR_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dvap_pkg::in_item_t in_data,
  output logic              push,
  output dvap_pkg::job_t    push_job,
  input  logic              push_ready
);

  logic [ADDR_BITS-1:0] previous_address;
  logic                 have_base;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] delta;
  logic [dvap_pkg::DELTA_BITS-1:0] delta_ext;
  logic                 accept;
  logic                 take_base;

  assign in_ready  = push_ready;
  assign accept    = in_valid && in_ready;
  assign addr      = in_data.address[ADDR_BITS-1:0];
  assign delta     = addr - previous_address;
  assign delta_ext = dvap_pkg::DELTA_BITS'(delta);
  assign take_base = in_data.start_table || !have_base;

  assign push            = accept && !take_base && (delta != '0);
  assign push_job.delta  = delta_ext;
  assign push_job.nbytes = dvap_pkg::byte_count(delta_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_address <= '0;
      have_base        <= 1'b0;
    end else if (accept) begin
      // Repeated addresses leave the state alone; both other cases keep the address.
      if (take_base || delta != '0) begin
        previous_address <= addr;
      end
      have_base <= 1'b1;
    end
  end

`ifndef SYNTH
  a_push_has_base: assert property (@(posedge clk) disable iff (rst)
    push |-> have_base && push_job.delta != '0)
    else $error("delta queued without a base or with zero value");
  a_base_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> have_base)
    else $error("base not taken after an accepted address");
`endif

endmodule

// File: rtl/dvap_fifo.sv
module dvap_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dvap_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output dvap_pkg::job_t head,
  output logic           head_valid
);

  localparam int PtrBits = (dvap_pkg::QUEUE_DEPTH > 1) ? $clog2(dvap_pkg::QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(dvap_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(dvap_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntBits-1:0] Full = CntBits'(dvap_pkg::QUEUE_DEPTH);

  dvap_pkg::job_t       entries [dvap_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [CntBits-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != Full);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("queue count beyond depth");
  a_head_nbytes: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.nbytes >= 3'd1 && head.nbytes <= 3'd5)
    else $error("queued job with an impossible byte count");
`endif

endmodule

// File: rtl/dvap_back.sv
module dvap_back (
  input  logic               clk,
  input  logic               rst,
  input  dvap_pkg::job_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output dvap_pkg::out_item_t out_data
);

  logic [dvap_pkg::DELTA_BITS-1:0] cur_delta;
  logic [dvap_pkg::COUNT_BITS-1:0] cur_left;
  logic                            slot_free;
  logic                            emit;
  logic [dvap_pkg::DELTA_BITS-1:0] src_delta;
  logic [dvap_pkg::COUNT_BITS-1:0] src_left;
  logic [dvap_pkg::COUNT_BITS-1:0] src_k;
  logic [dvap_pkg::GROUP_BITS-1:0] grp;

  assign slot_free = !out_valid || out_ready;
  assign pop       = slot_free && (cur_left == '0) && head_valid;
  assign emit      = slot_free && ((cur_left != '0) || head_valid);

  // With nothing left of the current delta, the queue head gives its first byte directly.
  assign src_delta = (cur_left != '0) ? cur_delta : head.delta;
  assign src_left  = (cur_left != '0) ? cur_left : head.nbytes;
  assign src_k     = src_left - 1'b1;
  assign grp       = dvap_pkg::group_of(src_delta, src_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        cur_left  <= src_k;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_delta <= head.delta;
    end
    if (emit) begin
      out_data.code_byte <= (src_k != '0) ? (dvap_pkg::MORE_FLAG | 8'(grp)) : 8'(grp);
      out_data.last_byte <= (src_k == '0);
    end
  end

`ifndef SYNTH
  a_flag_matches_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_byte == !out_data.code_byte[7]))
    else $error("continuation flag disagrees with last byte");
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    cur_left <= 3'd4)
    else $error("more than five bytes for one delta");
  a_no_pop_mid_delta: assert property (@(posedge clk) disable iff (rst)
    (cur_left != '0) |-> !pop)
    else $error("queue popped while a delta is still being sent");
`endif

endmodule

// File: rtl/delta_vlq_address_packer_top.sv
// Delta packer for sorted code addresses. Each accepted address is either taken as
// a table base (start_table set, or no base yet), dropped as a repeat, or turned into
// its difference from the previous kept address, sent as 1 to 5 big-endian 7-bit
// code bytes, with bit 7 set on all but the last. Input takes one address per cycle
// while the two-entry delta queue has room; the byte serializer at the output sends
// one code byte per cycle while out_ready allows, and bases and repeats send no
// code bytes. A delta's first byte is registered twice, in a queue entry and then
// in the output register, before it appears at the output.
module delta_vlq_address_packer_top #(
  parameter int ADDR_BITS = dvap_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dvap_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dvap_pkg::out_item_t out_data
);

  logic           push;
  logic           push_ready;
  dvap_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  dvap_pkg::job_t head;

  dvap_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_job  (push_job),
    .push_ready(push_ready)
  );

  dvap_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .push_ready(push_ready),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  dvap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
